// ===== rtl/core/gpc_pkg.sv =====
// Shared constants for the grid path counter: modulus, field widths,
// configuration register indexes and default sizes. No dependencies.
package gpc_pkg;

	localparam int COUNT_W = 30;            // width of one path count
	localparam int CFG_W   = 9;             // width of every configuration register
	localparam int CFG_IDX_W = 2;           // width of the register index

	localparam logic [COUNT_W:0] PATH_MOD = 31'd1000000007;

	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_CONV = 511;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_ROWS = 2'd0,
		CFG_GRID_COLS = 2'd1,
		CFG_MAX_CONV  = 2'd2
	} cfg_index_t;

endpackage

// ===== rtl/core/grid_path_count_with_conversions.sv =====
// Top level of the grid path counter: sequencer, configuration registers
// and output register. Depends on gpc_pkg, gpc_ram and gpc_modadd.

// Counts right/down paths from the top-left to the bottom-right cell of a
// grid_rows x grid_cols grid, where a path may cross at most K blocked cells
// (K = max_conversions, clamped to MAX_CONV; start and end cells count).
// Cells arrive one item per cell on the slave stream, row-major, as a
// blocked bit in s_tdata[0]. After the last cell of a grid one item carrying
// the path count modulo 1000000007 leaves on the master stream; every other
// cell gives no result. A write to any configuration register starts a new
// grid, and a new grid also starts automatically after each result.
// Each cell is taken in, then its K+1 levels are streamed through the row
// store at one level a cycle and the read pipeline drains; s_tready is low
// meanwhile. After the last cell of a grid a sweep sums its levels and the
// sum is loaded into the output register once it is free. The pace is set
// by the single write port of the row store and the one shared modular
// adder: each level needs one read of the cell above and the cell to the
// left and one write-back. The row store holds 2^ceil(log2(MAX_COLS)) x
// 2^ceil(log2(MAX_CONV+1)) counts and needs no clearing: every entry whose
// value is used has been written earlier in the same grid.
module grid_path_count_with_conversions #(
	parameter int MAX_COLS = gpc_pkg::DEF_MAX_COLS,
	parameter int MAX_CONV = gpc_pkg::DEF_MAX_CONV
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpc_pkg::CFG_W-1:0]     cfg_data,
	// cell items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] blocked, [7:1] zero
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata    // [29:0] path_count, [31:30] zero
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;      // column index bits
	localparam int LW = (MAX_CONV > 0) ? $clog2(MAX_CONV + 1) : 1;  // level index bits
	localparam int AW = CW + LW;
	localparam int DEPTH = 2 ** AW;
	localparam int RW = gpc_pkg::CFG_W;                               // row index bits
	localparam int NW = gpc_pkg::COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_SUM,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [gpc_pkg::CFG_W-1:0] grid_rows_q;
	logic [gpc_pkg::CFG_W-1:0] grid_cols_q;
	logic [gpc_pkg::CFG_W-1:0] max_conv_q;

	// grid position
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;

	// sequencer
	logic          blocked_q;
	logic [LW-1:0] lvl_q;       // level whose read is issued this cycle
	logic          issue_q;     // a read is issued this cycle
	logic          p_s1;        // read data is valid this cycle
	logic [LW-1:0] lvl_s1;      // level the read data belongs to
	logic          nul_s1;      // level below the blocked step: value is zero
	logic          one_s1;      // source level zero: start cell seeds one here
	logic [NW-1:0] acc_q;
	logic [NW-1:0] m_data_q;
	logic          m_valid_q;

	// effective configuration
	logic [LW-1:0] k_eff;
	logic [CW-1:0] last_col;
	logic [RW-1:0] last_row;

	always_comb begin
		if (int'(max_conv_q) > MAX_CONV) begin
			k_eff = LW'(MAX_CONV);
		end else begin
			k_eff = LW'(max_conv_q);
		end

		if (grid_cols_q == '0) begin
			last_col = '0;
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			last_col = CW'(MAX_COLS - 1);
		end else begin
			last_col = CW'(grid_cols_q - 1'b1);
		end

		if (grid_rows_q == '0) begin
			last_row = '0;
		end else begin
			last_row = grid_rows_q - 1'b1;
		end
	end

	// read addresses: port A is the cell above (or the summed cell), B the left one
	logic [LW-1:0] src_lvl;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [CW-1:0] left_col;

	assign src_lvl  = lvl_q - LW'(blocked_q);
	assign left_col = col_q - 1'b1;

	always_comb begin
		if (state_q == ST_SUM) begin
			rd_addr_a = {last_col, lvl_q};
		end else begin
			rd_addr_a = {col_q, src_lvl};
		end
		rd_addr_b = {left_col, src_lvl};
	end

	logic [NW-1:0] rd_data_a;
	logic [NW-1:0] rd_data_b;
	logic [NW-1:0] add_a;
	logic [NW-1:0] add_b;
	logic [NW-1:0] add_sum;
	logic          wr_en;
	logic          at_start;

	assign at_start = (row_q == '0) && (col_q == '0);
	assign wr_en    = (state_q == ST_CELL) && p_s1;

	// Operand select for the shared adder: cell update or level sum.
	always_comb begin
		add_a = '0;
		add_b = '0;
		if (state_q == ST_SUM) begin
			add_a = acc_q;
			add_b = rd_data_a;
		end else if (nul_s1) begin
			add_a = '0;
		end else if (at_start) begin
			add_a = NW'(one_s1);
		end else begin
			if (row_q != '0) begin
				add_a = rd_data_a;
			end
			if (col_q != '0) begin
				add_b = rd_data_b;
			end
		end
	end

	gpc_modadd u_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	gpc_ram #(
		.WIDTH (NW),
		.DEPTH (DEPTH)
	) u_row_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   ({col_q, lvl_s1}),
		.wr_data   (add_sum),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(32 - NW){1'b0}}, m_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grid_rows_q <= gpc_pkg::CFG_W'(1);
			grid_cols_q <= gpc_pkg::CFG_W'(1);
			max_conv_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			blocked_q   <= 1'b0;
			lvl_q       <= '0;
			issue_q     <= 1'b0;
			p_s1        <= 1'b0;
			lvl_s1      <= '0;
			nul_s1      <= 1'b0;
			one_s1      <= 1'b0;
			acc_q       <= '0;
			m_data_q    <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			// drop the result once taken
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			// register the issued read's valid, level and flags to match the read data
			p_s1   <= issue_q;
			lvl_s1 <= lvl_q;
			nul_s1 <= (lvl_q == '0) && blocked_q;
			one_s1 <= (src_lvl == '0);

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						blocked_q <= s_tdata[0];
						lvl_q     <= k_eff;
						issue_q   <= 1'b1;
						state_q   <= ST_CELL;
					end
				end
				ST_CELL: begin
					// levels run from K down so a lower source level is still old
					if (issue_q) begin
						if (lvl_q == '0) begin
							issue_q <= 1'b0;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end
					if (p_s1 && !issue_q) begin
						if (col_q == last_col) begin
							col_q <= '0;
							if (row_q == last_row) begin
								row_q   <= '0;
								lvl_q   <= '0;
								issue_q <= 1'b1;
								acc_q   <= '0;
								state_q <= ST_SUM;
							end else begin
								row_q   <= row_q + 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SUM: begin
					// sweep the last cell's levels upward, accumulating
					if (issue_q) begin
						if (lvl_q == k_eff) begin
							issue_q <= 1'b0;
						end else begin
							lvl_q <= lvl_q + 1'b1;
						end
					end
					if (p_s1) begin
						acc_q <= add_sum;
						if (!issue_q) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (!m_valid_q || m_tready) begin
						m_data_q  <= acc_q;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// user writes configuration in idle only (unchecked); valid ones restart the grid
			if (cfg_wr_en) begin
				unique case (cfg_index)
					gpc_pkg::CFG_GRID_ROWS: begin
						grid_rows_q <= cfg_data;
						row_q       <= '0;
						col_q       <= '0;
					end
					gpc_pkg::CFG_GRID_COLS: begin
						grid_cols_q <= cfg_data;
						row_q       <= '0;
						col_q       <= '0;
					end
					gpc_pkg::CFG_MAX_CONV: begin
						max_conv_q <= cfg_data;
						row_q      <= '0;
						col_q      <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/gpc_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module gpc_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// ===== rtl/core/gpc_modadd.sv =====
// Modular adder shared by the cell update and the final level sum.
// Depends on gpc_pkg for the count width and modulus.
module gpc_modadd (
	input  logic [gpc_pkg::COUNT_W-1:0] a,
	input  logic [gpc_pkg::COUNT_W-1:0] b,
	output logic [gpc_pkg::COUNT_W-1:0] sum
);

	logic [gpc_pkg::COUNT_W:0] raw;
	logic [gpc_pkg::COUNT_W:0] red;

	// Both operands are below the modulus, so one subtract suffices.
	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		red = raw - gpc_pkg::PATH_MOD;
		if (raw >= gpc_pkg::PATH_MOD) begin
			sum = red[gpc_pkg::COUNT_W-1:0];
		end else begin
			sum = raw[gpc_pkg::COUNT_W-1:0];
		end
	end

endmodule
